>>> design/srs_pkg.sv
// shared types and constants for the stable rank sorter
package srs_pkg;

    // width of the one-based position field on the result channel
    localparam int POS_W = 6;

    // back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_GET,
        B_SCAN,
        B_OWN,
        B_REC,
        B_OUT
    } back_state_t;

endpackage

>>> design/srs_channels.sv
// valid/ready channel interfaces for records in and sorted results out
interface srs_in_if #(
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] sort_key;
    logic [TAG_BITS-1:0] record_tag;
    logic                last_item;

    modport source (output valid, output sort_key, output record_tag, output last_item,
                    input ready);
    modport sink   (input valid, input sort_key, input record_tag, input last_item,
                    output ready);
endinterface

interface srs_out_if #(
    parameter int KEY_BITS = 8,
    parameter int TAG_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [srs_pkg::POS_W-1:0] sorted_position;
    logic [KEY_BITS-1:0]      out_key;
    logic [TAG_BITS-1:0]      out_tag;
    logic                     last_result;

    modport source (output valid, output sorted_position, output out_key, output out_tag,
                    output last_result, input ready);
    modport sink   (input valid, input sorted_position, input out_key, input out_tag,
                    input last_result, output ready);
endinterface

>>> design/srs_front.sv
// front end: takes records in and marks the one that closes a set
module srs_front #(
    parameter int MAX_ITEMS = 32,
    parameter int KEY_BITS  = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    srs_in_if.sink                         rec_in,
    output logic                           push_valid,
    input  logic                           push_ready,
    output logic [KEY_BITS+TAG_BITS:0]     push_data
);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_eff;
    logic             accept;

    // a record taking the last free entry closes the set
    assign last_eff   = rec_in.last_item || (cnt_reg == CNT_W'(MAX_ITEMS - 1));
    assign push_valid = rec_in.valid;
    assign rec_in.ready = push_ready;
    assign push_data  = {last_eff, rec_in.record_tag, rec_in.sort_key};
    assign accept     = rec_in.valid && push_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last_eff)
                cnt_next = '0;
            else
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end
endmodule

>>> design/srs_queue.sv
// two-entry queue between front and back end
module srs_queue #(
    parameter int DATA_W = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    logic [DATA_W-1:0] mem_reg [2];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [1:0]        fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        fill_next = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_data;
    end
endmodule

>>> design/srs_back.sv
// back end: stores a set, ranks it with one comparator and emits it in order
module srs_back #(
    parameter int MAX_ITEMS = 32,
    parameter int KEY_BITS  = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  logic [KEY_BITS+TAG_BITS:0] pop_data,
    srs_out_if.source                  res_out
);
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    srs_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    s_reg, s_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [KEY_BITS-1:0] key_i_reg, key_i_next;

    logic [KEY_BITS-1:0] key_mem   [MAX_ITEMS];
    logic [TAG_BITS-1:0] tag_mem   [MAX_ITEMS];
    logic [IDX_W-1:0]    owner_mem [MAX_ITEMS];
    logic [KEY_BITS-1:0] key_rd_reg;
    logic [TAG_BITS-1:0] tag_rd_reg;
    logic [IDX_W-1:0]    owner_rd_reg;

    logic                      out_vld_reg, out_vld_next;
    logic [srs_pkg::POS_W-1:0] out_pos_reg;
    logic [KEY_BITS-1:0]       out_key_reg;
    logic [TAG_BITS-1:0]       out_tag_reg;
    logic                      out_last_reg;
    logic                      out_load;

    logic [IDX_W-1:0]    rd_addr;
    logic                store_we;
    logic                own_we;
    logic                less;
    logic [CNT_W-1:0]    pos_sum;
    logic [CNT_W-1:0]    j_inc;
    logic [CNT_W-1:0]    i_inc;
    logic [CNT_W-1:0]    cnt_last;
    logic [CNT_W:0]      pos_one;
    logic                q_last;
    logic [KEY_BITS-1:0] q_key;
    logic [TAG_BITS-1:0] q_tag;

    assign q_key  = pop_data[KEY_BITS-1:0];
    assign q_tag  = pop_data[KEY_BITS+TAG_BITS-1:KEY_BITS];
    assign q_last = pop_data[KEY_BITS+TAG_BITS];

    // stable rank: smaller keys, plus equal keys that arrived earlier
    assign less     = (key_rd_reg < key_i_reg) || ((key_rd_reg == key_i_reg) && (j_reg < i_reg));
    assign pos_sum  = pos_reg + CNT_W'(less);
    assign j_inc    = j_reg + CNT_W'(1);
    assign i_inc    = i_reg + CNT_W'(1);
    assign cnt_last = cnt_reg - CNT_W'(1);
    assign pos_one  = (CNT_W+1)'(s_reg) + (CNT_W+1)'(1);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        s_next       = s_reg;
        pos_next     = pos_reg;
        key_i_next   = key_i_reg;
        rd_addr      = j_reg[IDX_W-1:0];
        store_we     = 1'b0;
        own_we       = 1'b0;
        pop_ready    = 1'b0;
        out_load     = 1'b0;
        out_vld_next = out_vld_reg && !res_out.ready;
        case (state_reg)
            srs_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    store_we = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (q_last)
                    begin
                        i_next     = '0;
                        state_next = srs_pkg::B_LOAD;
                    end
                end
            end
            srs_pkg::B_LOAD:
            begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = srs_pkg::B_GET;
            end
            srs_pkg::B_GET:
            begin
                key_i_next = key_rd_reg;
                rd_addr    = '0;
                j_next     = '0;
                pos_next   = '0;
                state_next = srs_pkg::B_SCAN;
            end
            srs_pkg::B_SCAN:
            begin
                pos_next = pos_sum;
                if (j_reg == cnt_last)
                begin
                    own_we  = 1'b1;
                    i_next  = i_inc;
                    rd_addr = i_inc[IDX_W-1:0];
                    if (i_reg == cnt_last)
                    begin
                        s_next     = '0;
                        state_next = srs_pkg::B_OWN;
                    end
                    else
                        state_next = srs_pkg::B_GET;
                end
                else
                begin
                    j_next  = j_inc;
                    rd_addr = j_inc[IDX_W-1:0];
                end
            end
            srs_pkg::B_OWN:
            begin
                state_next = srs_pkg::B_REC;
            end
            srs_pkg::B_REC:
            begin
                rd_addr    = owner_rd_reg;
                state_next = srs_pkg::B_OUT;
            end
            srs_pkg::B_OUT:
            begin
                // keep the record read steady while the output register is full
                rd_addr = owner_rd_reg;
                if (!out_vld_reg || res_out.ready)
                begin
                    out_load     = 1'b1;
                    out_vld_next = 1'b1;
                    if (s_reg == cnt_last)
                    begin
                        cnt_next   = '0;
                        state_next = srs_pkg::B_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + CNT_W'(1);
                        state_next = srs_pkg::B_OWN;
                    end
                end
            end
            default:
            begin
                state_next = srs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srs_pkg::B_IDLE;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            s_reg       <= '0;
            pos_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            s_reg       <= s_next;
            pos_reg     <= pos_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_i_reg <= key_i_next;
        if (out_load)
        begin
            out_pos_reg  <= srs_pkg::POS_W'(pos_one);
            out_key_reg  <= key_rd_reg;
            out_tag_reg  <= tag_rd_reg;
            out_last_reg <= (s_reg == cnt_last);
        end
    end

    // record stores, one read port each
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            key_mem[cnt_reg[IDX_W-1:0]] <= q_key;
            tag_mem[cnt_reg[IDX_W-1:0]] <= q_tag;
        end
        key_rd_reg <= key_mem[rd_addr];
        tag_rd_reg <= tag_mem[rd_addr];
    end

    // sorted slot to arrival index
    always_ff @(posedge clk)
    begin
        if (own_we)
            owner_mem[pos_sum[IDX_W-1:0]] <= i_reg[IDX_W-1:0];
        owner_rd_reg <= owner_mem[s_reg[IDX_W-1:0]];
    end

    assign res_out.valid           = out_vld_reg;
    assign res_out.sorted_position = out_pos_reg;
    assign res_out.out_key         = out_key_reg;
    assign res_out.out_tag         = out_tag_reg;
    assign res_out.last_result     = out_last_reg;
endmodule

>>> design/stable_rank_sort.sv
// stable rank sorter top level: records in, sorted records out
//
// records come in one item per cycle into the store while the back end is
// idle; the item flagged last, or the one that fills the store, closes the
// set. the set of n records is then ranked by a single key comparator reading
// one stored key per cycle: each record's key is fetched, compared with every
// stored key, and its arrival index written to the slot table at its rank.
// results then leave one at a time, each through a slot table read, a record
// read and the output register, waiting while the output register is full.
// equal keys keep their arrival order; each result carries its one-based
// position and the final result of a set is flagged.
// the front end and a two-entry queue keep taking records while the back end
// is busy, until the queue fills; the output register lets the next set load
// while the last result still waits to be taken.
module stable_rank_sort #(
    parameter int MAX_ITEMS = 32,
    parameter int KEY_BITS  = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    srs_in_if.sink    rec_in,
    srs_out_if.source res_out
);
    // queue entry: {closes set, tag, key}
    localparam int REC_W = KEY_BITS + TAG_BITS + 1;

    logic             push_valid;
    logic             push_ready;
    logic [REC_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_ready;
    logic [REC_W-1:0] pop_data;

    // front end: accept and classify each item
    srs_front #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_in     (rec_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue lets either side stall on its own
    srs_queue #(
        .DATA_W (REC_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: store, rank and emit
    srs_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res_out   (res_out)
    );
endmodule

>>> design/srs_checker.sv
// port-level checks on result hold, ordering and positions, bound to the top level
module srs_checker #(
    parameter int KEY_BITS = 8
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [srs_pkg::POS_W-1:0] sorted_position,
    input logic [KEY_BITS-1:0]       out_key,
    input logic                      last_result
);
    logic                      out_acc;
    logic [srs_pkg::POS_W-1:0] exp_pos_reg;
    logic [KEY_BITS-1:0]       prev_key_reg;
    logic                      run_reg;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pos_reg <= srs_pkg::POS_W'(1);
            run_reg     <= 1'b0;
        end
        else if (out_acc)
        begin
            exp_pos_reg <= last_result ? srs_pkg::POS_W'(1)
                                       : sorted_position + srs_pkg::POS_W'(1);
            run_reg     <= !last_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_acc)
            prev_key_reg <= out_key;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    a_pos_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> sorted_position == exp_pos_reg)
        else $error("result position out of sequence");

    a_key_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && run_reg |-> out_key >= prev_key_reg)
        else $error("result keys not ascending");
endmodule

bind stable_rank_sort srs_checker #(
    .KEY_BITS (KEY_BITS)
) u_srs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (res_out.valid),
    .out_ready       (res_out.ready),
    .sorted_position (res_out.sorted_position),
    .out_key         (res_out.out_key),
    .last_result     (res_out.last_result)
);
